// File: rtl/sdgr_pkg.sv
// ----------------------------------------------------------------------------
// sdgr_pkg
// types, font rom and microprogram of the signed decimal glyph renderer
// ----------------------------------------------------------------------------
package sdgr_pkg;

  localparam int DIGITS_DEF        = 5;
  localparam int GLYPH_COLUMNS_DEF = 3;

  localparam int VALUE_W = 16;
  localparam int FL_W    = 4;
  localparam int NP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int MAG_W   = 16;
  localparam int DIGIT_W = 4;
  localparam int GCOL_W  = 3;

  // divide by ten: q = (x * 52429) >> 19, exact for x below 81920
  localparam int RECIP_W     = 17;
  localparam int RECIP       = 52429;
  localparam int RECIP_SHIFT = 19;

  localparam logic [NP_W-1:0] NP_MAX = 2'd2;

  // font rom covers '+' through '9'
  localparam int FONT_COUNT = 15;
  localparam int FONT_COLS  = 3;
  localparam int FIDX_W     = 4;

  localparam logic [FIDX_W-1:0] FI_PLUS   = 4'd0;
  localparam logic [FIDX_W-1:0] FI_MINUS  = 4'd2;
  localparam logic [FIDX_W-1:0] FI_PERIOD = 4'd3;
  localparam logic [FIDX_W-1:0] FI_ZERO   = 4'd5;

  localparam logic [BYTE_W-1:0] FONT_ROM [FONT_COUNT][FONT_COLS] = '{
    '{8'h10, 8'h38, 8'h10},  // +
    '{8'ha0, 8'h60, 8'h00},  // ,
    '{8'h10, 8'h10, 8'h10},  // -
    '{8'h60, 8'h60, 8'h00},  // .
    '{8'h60, 8'h18, 8'h06},  // /
    '{8'h7c, 8'h42, 8'h7c},  // 0
    '{8'h44, 8'h7e, 8'h40},  // 1
    '{8'h64, 8'h52, 8'h4c},  // 2
    '{8'h4a, 8'h4a, 8'h34},  // 3
    '{8'h38, 8'h24, 8'h7e},  // 4
    '{8'h4e, 8'h4a, 8'h32},  // 5
    '{8'h3c, 8'h4a, 8'h32},  // 6
    '{8'h62, 8'h1a, 8'h06},  // 7
    '{8'h76, 8'h4a, 8'h76},  // 8
    '{8'h4c, 8'h52, 8'h3c}   // 9
  };

  // columns past the rom width are blank
  function automatic logic [BYTE_W-1:0] glyph_col(logic [FIDX_W-1:0] idx,
                                                  logic [GCOL_W-1:0] col);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (int'(idx) < FONT_COUNT && int'(col) < FONT_COLS) begin
      b = FONT_ROM[idx][col[1:0]];
    end
    return b;
  endfunction

  // microcode control word
  typedef enum logic [1:0] {ACT_WAIT, ACT_SPLIT, ACT_SETUP, ACT_EMIT} act_t;
  typedef enum logic [1:0] {SRC_SIGN, SRC_INT, SRC_PERIOD, SRC_FRAC} src_t;
  typedef logic [2:0] upc_t;

  localparam upc_t STEP_IDLE   = 3'd0;
  localparam upc_t STEP_SPLIT  = 3'd1;
  localparam upc_t STEP_SETUP  = 3'd2;
  localparam upc_t STEP_SIGN   = 3'd3;
  localparam upc_t STEP_INT    = 3'd4;
  localparam upc_t STEP_PERIOD = 3'd5;
  localparam upc_t STEP_FRAC   = 3'd6;

  typedef struct packed {
    act_t act;
    src_t src;
    upc_t nxt;
  } uword_t;

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      STEP_IDLE:   w = '{act: ACT_WAIT,  src: SRC_SIGN,   nxt: STEP_SPLIT};
      STEP_SPLIT:  w = '{act: ACT_SPLIT, src: SRC_SIGN,   nxt: STEP_SETUP};
      STEP_SETUP:  w = '{act: ACT_SETUP, src: SRC_SIGN,   nxt: STEP_SIGN};
      STEP_SIGN:   w = '{act: ACT_EMIT,  src: SRC_SIGN,   nxt: STEP_INT};
      STEP_INT:    w = '{act: ACT_EMIT,  src: SRC_INT,    nxt: STEP_PERIOD};
      STEP_PERIOD: w = '{act: ACT_EMIT,  src: SRC_PERIOD, nxt: STEP_FRAC};
      STEP_FRAC:   w = '{act: ACT_EMIT,  src: SRC_FRAC,   nxt: STEP_IDLE};
      default:     w = '{act: ACT_WAIT,  src: SRC_SIGN,   nxt: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/signed_decimal_glyph_renderer_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_glyph_renderer_core
// formats a signed 16-bit value as decimal text and streams its glyph columns
// ----------------------------------------------------------------------------
// sequence: digit split, setup, then sign, integer digits, period and fraction
//   steps; column bytes go out one per cycle while out_ready allows, with a gap
//   for each step passed over; a new item is taken only in the idle step
// reset: synchronous, clears step counter, column counter and output valid
module signed_decimal_glyph_renderer_core #(
  parameter int DIGITS        = sdgr_pkg::DIGITS_DEF,
  parameter int GLYPH_COLUMNS = sdgr_pkg::GLYPH_COLUMNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sdgr_pkg::VALUE_W-1:0] value,
  input  logic signed [sdgr_pkg::FL_W-1:0]    field_length,
  input  logic        [sdgr_pkg::NP_W-1:0]    decimal_places,
  input  logic                                show_plus,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [sdgr_pkg::BYTE_W-1:0]  column_byte,
  output logic                                last
);
  import sdgr_pkg::*;

  // digit index, digit position (holds DIGITS itself), glyph column counter
  localparam int IW = $clog2(DIGITS);
  localparam int PW = $clog2(DIGITS + 1);
  localparam int CW = $clog2(GLYPH_COLUMNS + 1);

  // sequencer
  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;

  // item registers
  logic                   neg;
  logic                   plus_r;
  logic signed [FL_W-1:0] fl_r;
  logic [NP_W-1:0]        np_r;
  logic [MAG_W-1:0]       mag;
  logic [IW-1:0]          cnt;
  logic [IW-1:0]          first_nz;
  logic [DIGIT_W-1:0]     digits [DIGITS];
  logic [PW-1:0]          pos;
  logic [CW-1:0]          col;

  // datapath
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [MAG_W-1:0]         quot;
  logic [MAG_W-1:0]         rem_w;
  logic [DIGIT_W-1:0]       rem;
  logic [PW-1:0]            start_val;
  logic [PW-1:0]            int_end;
  logic                     glyph_en;
  logic                     last_glyph;
  logic                     pad;
  logic                     slot_free;
  logic                     emit;
  logic                     glyph_done;
  logic [FIDX_W-1:0]        cur_idx;
  logic [BYTE_W-1:0]        cur_byte;

  assign uw = ucode(upc);

  // divide by ten through the reciprocal, one digit per split step
  assign prod  = mag * RECIP_W'(RECIP);
  assign quot  = MAG_W'(prod >> RECIP_SHIFT);
  assign rem_w = mag - (quot << 3) - (quot << 1);
  assign rem   = rem_w[DIGIT_W-1:0];

  // first digit shown: automatic width uses the leftmost nonzero digit
  always_comb begin
    int s;
    s = DIGITS - int'(fl_r);
    if (fl_r == -4'sd1) begin
      start_val = PW'(first_nz);
    end else if (s < 0) begin
      start_val = '0;
    end else if (s > DIGITS) begin
      start_val = PW'(DIGITS);
    end else begin
      start_val = PW'(s);
    end
  end

  assign int_end   = PW'(DIGITS) - PW'(np_r);
  assign pad       = (col == CW'(GLYPH_COLUMNS));
  assign slot_free = !out_valid || out_ready;

  // glyph selection for the current emit step
  always_comb begin
    glyph_en   = 1'b0;
    last_glyph = 1'b0;
    cur_idx    = FI_ZERO + FIDX_W'(digits[pos[IW-1:0]]);
    case (uw.src)
      SRC_SIGN: begin
        glyph_en   = neg || plus_r;
        last_glyph = (np_r == '0) && (pos >= PW'(DIGITS));
        cur_idx    = neg ? FI_MINUS : FI_PLUS;
      end
      SRC_INT: begin
        glyph_en   = pos < int_end;
        last_glyph = (np_r == '0) && (pos == PW'(DIGITS - 1));
      end
      SRC_PERIOD: begin
        glyph_en   = np_r != '0;
        cur_idx    = FI_PERIOD;
      end
      SRC_FRAC: begin
        glyph_en   = pos < PW'(DIGITS);
        last_glyph = pos == PW'(DIGITS - 1);
      end
      default: begin
        glyph_en = 1'b0;
      end
    endcase
  end

  // trailing blank column after every glyph
  assign cur_byte = pad ? '0 : glyph_col(cur_idx, GCOL_W'(col));

  // step sequencing from the control word
  always_comb begin
    upc_next   = upc;
    in_ready   = 1'b0;
    emit       = 1'b0;
    glyph_done = 1'b0;
    unique case (uw.act)
      ACT_WAIT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          upc_next = uw.nxt;
        end
      end
      ACT_SPLIT: begin
        if (cnt == '0) begin
          upc_next = uw.nxt;
        end
      end
      ACT_SETUP: begin
        upc_next = uw.nxt;
      end
      ACT_EMIT: begin
        if (!glyph_en) begin
          upc_next = uw.nxt;
        end else if (slot_free) begin
          emit = 1'b1;
          if (pad) begin
            glyph_done = 1'b1;
            // single glyphs leave after one pass, digit runs recheck the bound
            if (uw.src == SRC_SIGN || uw.src == SRC_PERIOD) begin
              upc_next = uw.nxt;
            end
          end
        end
      end
      default: begin
        upc_next = STEP_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= STEP_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
    end else begin
      upc <= upc_next;
      if (emit) begin
        out_valid <= 1'b1;
        col       <= pad ? '0 : col + CW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, digit buffer and output payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      neg      <= value[VALUE_W-1];
      // -32768 negates to 0x8000, its true magnitude as unsigned
      mag      <= value[VALUE_W-1] ? MAG_W'(~value + 1'b1) : MAG_W'(value);
      fl_r     <= field_length;
      np_r     <= (decimal_places > NP_MAX) ? NP_MAX : decimal_places;
      plus_r   <= show_plus;
      cnt      <= IW'(DIGITS - 1);
      first_nz <= IW'(DIGITS - 1);
    end
    if (uw.act == ACT_SPLIT) begin
      digits[cnt] <= rem;
      mag         <= quot;
      cnt         <= cnt - IW'(1);
      // digits come right to left, so the last nonzero seen is the leftmost
      if (rem != '0) begin
        first_nz <= cnt;
      end
    end
    if (uw.act == ACT_SETUP) begin
      pos <= start_val;
    end
    if (uw.act == ACT_EMIT && uw.src == SRC_PERIOD) begin
      pos <= int_end;
    end
    if (glyph_done && (uw.src == SRC_INT || uw.src == SRC_FRAC)) begin
      pos <= pos + PW'(1);
    end
    if (emit) begin
      column_byte <= cur_byte;
      last        <= pad && last_glyph;
    end
  end

`ifndef ASSERT_OFF
  // an accepted item starts the digit split right away
  a_accept_split: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (upc == STEP_SPLIT))
    else $error("accepted item did not enter digit split");

  // the final byte of a number is always a blank padding column
  a_last_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (column_byte == '0))
    else $error("last flag on a non-blank column");

  // the magnitude is fully consumed once all digits are split off
  a_split_done: assert property (@(posedge clk) disable iff (rst)
    (upc == STEP_SETUP) |-> (mag == '0))
    else $error("magnitude left over after digit split");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the signed decimal glyph renderer core
// ----------------------------------------------------------------------------
// A short table of numbers comes first: zero in automatic width, the 16-bit
// extremes, field lengths that are zero, too long or below -1, three decimal
// places, and numbers that render to nothing. A few rows carry their column
// bytes typed in. All other rows are checked against a local formatter with
// its own font table. Eighty random numbers follow, in four handshake
// mixes. Before each mix the sender holds off until every column has drained.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_DIGITS   = sdgr_pkg::DIGITS_DEF;
  localparam int GLYPH_COLS   = sdgr_pkg::GLYPH_COLUMNS_DEF;
  localparam int ITEMS_PER_MIX = 20;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 60;

  // ascii codes of the characters that can be rendered
  localparam int CH_PLUS   = 8'h2B;
  localparam int CH_MINUS  = 8'h2D;
  localparam int CH_PERIOD = 8'h2E;
  localparam int CH_ZERO   = 8'h30;

  // font for '+' through '9', three columns per entry, left column in the top byte
  localparam logic [23:0] GLYPH_FONT [15] = '{
    24'h103810, 24'ha06000, 24'h101010, 24'h606000, 24'h601806,
    24'h7c427c, 24'h447e40, 24'h64524c, 24'h4a4a34, 24'h38247e,
    24'h4e4a32, 24'h3c4a32, 24'h621a06, 24'h764a76, 24'h4c523c
  };

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  fl;
    logic [1:0]  np;
    logic        plus;
    logic        typed;     // column bytes below are the expected ones
    logic [3:0]  ncols;
    logic [63:0] cols;      // first column in the top byte
  } num_row_t;

  typedef struct packed {
    logic [7:0] cbyte;
    logic       last;
  } glyph_col_t;

  localparam int NUM_ROWS = 23;
  localparam num_row_t NUMBER_TABLE [NUM_ROWS] = '{
    // value         fl       np    plus  typed n    columns
    '{16'sd0,      -4'sd1,  2'd0, 1'b0, 1'b1, 4'd4, 64'h7c427c00_00000000}, // auto zero
    '{16'sd123,     4'sd0,  2'd0, 1'b0, 1'b1, 4'd0, 64'h0},                 // nothing
    '{-16'sd5,      4'sd0,  2'd0, 1'b0, 1'b1, 4'd4, 64'h10101000_00000000}, // sign only
    '{16'sd9,       4'sd0,  2'd0, 1'b1, 1'b1, 4'd4, 64'h10381000_00000000}, // plus only
    '{16'sd7,       4'sd1,  2'd0, 1'b0, 1'b1, 4'd4, 64'h621a0600_00000000},
    '{16'sd0,       4'sd1,  2'd0, 1'b1, 1'b1, 4'd8, 64'h10381000_7c427c00},
    '{16'sh7fff,   -4'sd1,  2'd0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{16'sh8000,   -4'sd1,  2'd0, 1'b0, 1'b0, 4'd0, 64'h0},                 // true magnitude
    '{16'sh8000,    4'sd5,  2'd2, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sh7fff,    4'sd5,  2'd2, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sd0,      -4'sd1,  2'd2, 1'b0, 1'b0, 4'd0, 64'h0},                 // auto zero, fraction
    '{16'sd1234,   -4'sd1,  2'd1, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sd42,      4'sd7,  2'd0, 1'b0, 1'b0, 4'd0, 64'h0},                 // length too large
    '{-16'sd42,    -4'sd8,  2'd1, 1'b0, 1'b0, 4'd0, 64'h0},                 // length below -1
    '{16'sd5,      -4'sd2,  2'd2, 1'b0, 1'b0, 4'd0, 64'h0},
    '{16'sd678,     4'sd3,  2'd3, 1'b0, 1'b0, 4'd0, 64'h0},                 // three places
    '{16'sd99,      4'sd1,  2'd2, 1'b0, 1'b0, 4'd0, 64'h0},                 // fraction wider
    '{-16'sd1,      4'sd4,  2'd1, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sd10000,  -4'sd1,  2'd0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{16'sd305,     4'sd2,  2'd0, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sd0,       4'sd0,  2'd0, 1'b0, 1'b1, 4'd0, 64'h0},                 // nothing at all
    '{16'sh8000,    4'sd6,  2'd3, 1'b1, 1'b0, 4'd0, 64'h0},
    '{16'sd1,       4'sd5,  2'd1, 1'b0, 1'b0, 4'd0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic signed [15:0] value          = '0;
  logic signed [3:0]  field_length   = '0;
  logic        [1:0]  decimal_places = '0;
  logic               show_plus      = 1'b0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic        [7:0]  column_byte;
  logic               col_last;

  // typed expectation travels alongside the payload and changes with it
  logic        row_typed = 1'b0;
  logic [3:0]  row_ncols = '0;
  logic [63:0] row_cols  = '0;

  glyph_col_t pending_cols[$];

  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;
  int numbers_taken  = 0;
  int cols_checked   = 0;
  int idle_cycles    = 0;

  signed_decimal_glyph_renderer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .value          (value),
    .field_length   (field_length),
    .decimal_places (decimal_places),
    .show_plus      (show_plus),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .column_byte    (column_byte),
    .last           (col_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // formats one number and queues the column bytes it should produce
  function automatic void predict_columns(input logic signed [15:0] v,
                                          input logic signed [3:0] fl,
                                          input logic [1:0] np_in,
                                          input logic plus);
    int mag, fln, start, np, idx;
    int dig [NUM_DIGITS];
    int chars[$];
    logic [7:0] cols[$];
    glyph_col_t gc;
    mag = int'(v);
    fln = int'(fl);
    if (mag < 0) begin
      mag = -mag;
    end
    np = (np_in > 2'd2) ? 2 : int'(np_in);
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      dig[i] = mag % 10;
      mag = mag / 10;
    end
    if (fln == -1) begin
      // automatic width: skip leading zeros, but always keep the last digit
      start = 0;
      while (start < NUM_DIGITS - 1 && dig[start] == 0) start++;
    end else begin
      start = NUM_DIGITS - fln;
      if (start < 0) start = 0;
      if (start > NUM_DIGITS) start = NUM_DIGITS;
    end
    if (v < 0) begin
      chars.push_back(CH_MINUS);
    end else if (plus) begin
      chars.push_back(CH_PLUS);
    end
    for (int i = start; i < NUM_DIGITS - np; i++) chars.push_back(CH_ZERO + dig[i]);
    if (np > 0) begin
      chars.push_back(CH_PERIOD);
      for (int i = NUM_DIGITS - np; i < NUM_DIGITS; i++) chars.push_back(CH_ZERO + dig[i]);
    end
    foreach (chars[k]) begin
      idx = chars[k] - CH_PLUS;
      for (int c = 0; c < GLYPH_COLS; c++) begin
        cols.push_back((c < 3) ? GLYPH_FONT[idx][23-8*c -: 8] : 8'h00);
      end
      cols.push_back(8'h00);  // blank spacer column
    end
    foreach (cols[k]) begin
      gc.cbyte = cols[k];
      gc.last  = (k == cols.size() - 1);
      pending_cols.push_back(gc);
    end
  endfunction

  // output checking and input-side prediction, both on the accepting edge
  always @(posedge clk) begin : col_check
    glyph_col_t exp_col;
    glyph_col_t typed_col;
    if (!rst) begin
      if (out_valid && out_ready) begin
        cols_checked++;
        if (pending_cols.size() == 0) begin
          $display("%0t: column %02h last %0b arrived with nothing expected",
                   $time, column_byte, col_last);
          mismatch_count++;
        end else begin
          exp_col = pending_cols.pop_front();
          if (column_byte !== exp_col.cbyte) begin
            $display("%0t: column_byte expected %02h, got %02h",
                     $time, exp_col.cbyte, column_byte);
            mismatch_count++;
          end
          if (col_last !== exp_col.last) begin
            $display("%0t: last expected %0b, got %0b", $time, exp_col.last, col_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        numbers_taken++;
        if (row_typed) begin
          for (int i = 0; i < row_ncols; i++) begin
            typed_col.cbyte = row_cols[63-8*i -: 8];
            typed_col.last  = (i == row_ncols - 1);
            pending_cols.push_back(typed_col);
          end
        end else begin
          predict_columns(value, field_length, decimal_places, show_plus);
        end
      end
    end
  end

  // receiver side back-pressure
  always @(posedge clk) begin
    out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  // a hang shows up as a long stretch with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_number(input num_row_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_gap_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    value          <= r.value;
    field_length   <= r.fl;
    decimal_places <= r.np;
    show_plus      <= r.plus;
    row_typed      <= r.typed;
    row_ncols      <= r.ncols;
    row_cols       <= r.cols;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender holds off until every queued column has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cols.size() != 0) @(posedge clk);
  endtask

  function automatic num_row_t random_number();
    num_row_t r;
    r = '0;
    case ($urandom_range(3))
      0: r.value = 16'($urandom_range(199)) - 16'd100;
      1: begin
        case ($urandom_range(3))
          0: r.value = 16'h8000;
          1: r.value = 16'h7fff;
          2: r.value = 16'h0000;
          default: r.value = 16'hffff;
        endcase
      end
      default: r.value = 16'($urandom);
    endcase
    // mostly lengths from -1 to 5, sometimes any code
    if ($urandom_range(7) == 0) begin
      r.fl = 4'($urandom);
    end else begin
      r.fl = 4'($urandom_range(6)) - 4'd1;
    end
    r.np   = 2'($urandom_range(3));
    r.plus = 1'($urandom_range(1));
    return r;
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) send_number(NUMBER_TABLE[i]);

    // random numbers: no idling, sender gaps, receiver stalls, then both lightly
    for (int mix = 0; mix < 4; mix++) begin
      wait_drained();
      in_gap_pct    = (mix == 1) ? 55 : (mix == 3) ? 11 : 0;
      out_stall_pct = (mix == 2) ? 55 : (mix == 3) ? 11 : 0;
      repeat (ITEMS_PER_MIX) send_number(random_number());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("rendered %0d numbers (%0d from the table) under four handshake mixes",
             numbers_taken, NUM_ROWS);
    $display("compared %0d column bytes, %0d mismatches", cols_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
